@@ rtl/core/mmam_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmam_pkg: shared types and constants of the MIDI message action matcher
// Word layouts of the request and response channels, the stored entry
// fields, the decoded message and the status and register codes.
// ----------------------------------------------------------------------------
package mmam_pkg;

   // request word fields
   typedef struct packed {
      logic       func;
      logic [4:0] entry_index;
      logic [7:0] entry_target;
      logic       entry_kind;
      logic [6:0] entry_number;
      logic [4:0] entry_channel;
      logic       entry_momentary;
      logic       entry_button;
      logic [7:0] status_byte;
      logic [6:0] data_first;
      logic [6:0] data_second;
   } req_word_type;

   // response word fields
   typedef struct packed {
      logic       event_kind;
      logic [4:0] channel;
      logic       message_kind;
      logic [6:0] control_number;
      logic [7:0] target;
      logic [6:0] action_value;
      logic       pressed;
      logic       last;
   } rsp_word_type;

   // mapping entry without its target
   typedef struct packed {
      logic       kind;
      logic [6:0] number;
      logic [4:0] channel;
      logic       momentary;
      logic       button;
   } entry_type;

   // decoded message broadcast to the cells
   typedef struct packed {
      logic       kind;
      logic [6:0] number;
      logic [4:0] channel;
      logic [6:0] value;
      logic       release_evt;
   } msg_type;

   // request functions
   localparam logic FUNC_WRITE_ENTRY = 1'b0;
   localparam logic FUNC_MIDI        = 1'b1;

   // status nibbles
   localparam logic [3:0] STATUS_NOTE_OFF   = 4'h8;
   localparam logic [3:0] STATUS_NOTE_ON    = 4'h9;
   localparam logic [3:0] STATUS_CONTROLLER = 4'hB;

   // message kinds
   localparam logic KIND_NOTE       = 1'b0;
   localparam logic KIND_CONTROLLER = 1'b1;

   // event kinds
   localparam logic EVENT_LEARN  = 1'b0;
   localparam logic EVENT_ACTION = 1'b1;

   // register indexes (address bit 2)
   localparam logic REG_LEARN_ENABLE  = 1'b0;
   localparam logic REG_ACTION_ENABLE = 1'b1;

endpackage

@@ rtl/core/mmam_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmam_req_if / mmam_rsp_if: valid-ready channels of the matcher
// A word moves at a rising edge where valid and ready are both high.
// ----------------------------------------------------------------------------
interface mmam_req_if;
   import mmam_pkg::*;
   logic         valid;
   logic         ready;
   req_word_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface mmam_rsp_if;
   import mmam_pkg::*;
   logic         valid;
   logic         ready;
   rsp_word_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/mmam_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmam_cell: one mapping slot of the matcher chain
// Holds one entry, evaluates it against a new message on a load and
// then passes its candidate (hit flag and target) toward the head.
// ----------------------------------------------------------------------------
module mmam_cell #(
   parameter int TARGET_BITS = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    wr_en,
   input  logic [TARGET_BITS-1:0]  wr_target,
   input  mmam_pkg::entry_type     wr_entry,
   input  logic                    load,
   input  mmam_pkg::msg_type       msg,
   input  logic                    shift,
   input  logic                    next_hit,
   input  logic [TARGET_BITS-1:0]  next_target,
   output logic                    cand_hit,
   output logic [TARGET_BITS-1:0]  cand_target
);
   import mmam_pkg::*;

   logic                   valid_ff;
   logic [TARGET_BITS-1:0] target_ff;
   entry_type              entry_ff;
   logic                   hit_ff, hit_in;
   logic [TARGET_BITS-1:0] cand_ff, cand_in;
   logic                   match;

   // entry storage, marked empty at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (wr_en) begin
         valid_ff <= 1'b1;
      end
      if (wr_en) begin
         target_ff <= wr_target;
         entry_ff  <= wr_entry;
      end
   end

   // match rule of one entry against the decoded message
   always_comb begin
      match = valid_ff && (target_ff != '0) && (entry_ff.kind == msg.kind)
              && (entry_ff.number == msg.number)
              && ((entry_ff.channel == 5'd0) || (entry_ff.channel == msg.channel));
      if (msg.release_evt) begin
         match = match && entry_ff.momentary;
      end else begin
         match = match && !(entry_ff.button && (msg.value == 7'd0));
      end
   end

   // candidate: load own result, then shift toward the head
   always_comb begin
      hit_in  = hit_ff;
      cand_in = cand_ff;
      if (load) begin
         hit_in  = match;
         cand_in = target_ff;
      end else if (shift) begin
         hit_in  = next_hit;
         cand_in = next_target;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in;
      end
      cand_ff <= cand_in;
   end

   assign cand_hit    = hit_ff;
   assign cand_target = cand_ff;

endmodule

@@ rtl/core/midi_message_action_matcher_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_message_action_matcher_core: MIDI message to action matcher
// Keeps a chain of mapping cells and turns each note or controller message
// into an optional learn event and, if enabled, one action event per match.
// ----------------------------------------------------------------------------
// Usage:
//   req (sink): func 0 words write one table cell, func 1 words carry a raw
//   MIDI message. rsp (source): result words, the final one of a message has
//   last set. csr: APB registers learn_enable at 0x0, action_enable at 0x4,
//   written by the user only while the block is idle, which it does not enforce.
//   A table write leaves the block idle. A message is decoded and all cells
//   are evaluated in the accept cycle; with actions enabled the candidates
//   then shift out of the cell chain one per cycle unless rsp holds them (with
//   actions disabled the scan is skipped). The next word is accepted only after
//   the last result of a message has passed the pending register into the
//   output register. Reset marks every cell empty and clears both registers and
//   the channels. When rsp stalls the chain holds its position once a hit finds
//   pending and output words both waiting; the output register lets one result
//   wait while the next hit is prepared.
// ----------------------------------------------------------------------------
module midi_message_action_matcher_core #(
   parameter int TABLE_ENTRIES = 32,
   parameter int TARGET_BITS   = 8
) (
   input  logic               clock,
   input  logic               reset,
   mmam_req_if.sink           req_chan,
   mmam_rsp_if.source         rsp_chan,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);
   import mmam_pkg::*;

   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_FLUSH = 2'd2;

   logic                   learn_en_ff, action_en_ff;
   logic [1:0]             state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   msg_type                msg_ff, msg_in;
   rsp_word_type           pend_ff, pend_in;
   logic                   pend_valid_ff, pend_valid_in;
   rsp_word_type           out_ff, out_in;
   logic                   out_valid_ff, out_valid_in;

   logic                   req_acc, msg_ok, do_load, do_shift;
   logic                   push, out_free;
   rsp_word_type           push_word, learn_word, action_word;
   logic [3:0]             status_hi;
   msg_type                msg_dec;
   logic [TARGET_BITS+7:0] tgt_wide_wr, tgt_wide_rd;
   logic [TARGET_BITS-1:0] wr_target;
   entry_type              wr_entry;
   logic [7:0]             head_target8;

   logic                   hit     [TABLE_ENTRIES+1];
   logic [TARGET_BITS-1:0] cand_tg [TABLE_ENTRIES+1];
   logic [TABLE_ENTRIES-1:0] wr_en;

   // configuration registers
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         learn_en_ff  <= 1'b0;
         action_en_ff <= 1'b0;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (csr_paddr[2])
            REG_LEARN_ENABLE:  learn_en_ff  <= csr_pwdata[0];
            REG_ACTION_ENABLE: action_en_ff <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_LEARN_ENABLE:  csr_prdata = {31'd0, learn_en_ff};
         REG_ACTION_ENABLE: csr_prdata = {31'd0, action_en_ff};
         default:           csr_prdata = 32'd0;
      endcase
   end

   // message decode
   assign status_hi = req_chan.data.status_byte[7:4];
   always_comb begin
      msg_ok              = 1'b1;
      msg_dec.number      = req_chan.data.data_first;
      msg_dec.value       = req_chan.data.data_second;
      msg_dec.channel     = {1'b0, req_chan.data.status_byte[3:0]} + 5'd1;
      msg_dec.kind        = KIND_NOTE;
      msg_dec.release_evt = 1'b0;
      case (status_hi)
         STATUS_NOTE_OFF: msg_dec.release_evt = 1'b1;
         STATUS_NOTE_ON:  msg_dec.release_evt = (req_chan.data.data_second == 7'd0);
         STATUS_CONTROLLER: msg_dec.kind = KIND_CONTROLLER;
         default: msg_ok = 1'b0;
      endcase
   end

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_acc        = req_chan.valid && req_chan.ready;
   assign do_load        = req_acc && (req_chan.data.func == FUNC_MIDI) && msg_ok;

   // table write data, target kept in TARGET_BITS
   assign tgt_wide_wr = {{TARGET_BITS{1'b0}}, req_chan.data.entry_target};
   assign wr_target   = tgt_wide_wr[TARGET_BITS-1:0];
   assign wr_entry    = '{kind:      req_chan.data.entry_kind,
                          number:    req_chan.data.entry_number,
                          channel:   req_chan.data.entry_channel,
                          momentary: req_chan.data.entry_momentary,
                          button:    req_chan.data.entry_button};

   // cell chain, cell 0 is the head
   assign hit[TABLE_ENTRIES]     = 1'b0;
   assign cand_tg[TABLE_ENTRIES] = '0;

   for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
      assign wr_en[i] = req_acc && (req_chan.data.func == FUNC_WRITE_ENTRY)
                        && (32'(req_chan.data.entry_index) == i);
      mmam_cell #(.TARGET_BITS(TARGET_BITS)) u_cell (
         .clock       (clock),
         .reset       (reset),
         .wr_en       (wr_en[i]),
         .wr_target   (wr_target),
         .wr_entry    (wr_entry),
         .load        (do_load),
         .msg         (msg_dec),
         .shift       (do_shift),
         .next_hit    (hit[i+1]),
         .next_target (cand_tg[i+1]),
         .cand_hit    (hit[i]),
         .cand_target (cand_tg[i])
      );
   end

   // result words
   assign tgt_wide_rd  = {8'd0, cand_tg[0]};
   assign head_target8 = tgt_wide_rd[7:0];

   always_comb begin
      learn_word                = '0;
      learn_word.event_kind     = EVENT_LEARN;
      learn_word.channel        = msg_dec.channel;
      learn_word.message_kind   = msg_dec.kind;
      learn_word.control_number = msg_dec.number;
      learn_word.pressed        = 1'b1;

      action_word                = '0;
      action_word.event_kind     = EVENT_ACTION;
      action_word.channel        = msg_ff.channel;
      action_word.message_kind   = msg_ff.kind;
      action_word.control_number = msg_ff.number;
      action_word.target         = head_target8;
      action_word.action_value   = msg_ff.release_evt ? 7'd0 : msg_ff.value;
      action_word.pressed        = !msg_ff.release_evt;
   end

   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign do_shift = (state_ff == ST_SCAN)
                     && !(hit[0] && pend_valid_ff && !out_free);

   // sequencer: pending word waits until the next hit or the end of the chain
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      msg_in        = msg_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      push          = 1'b0;
      push_word     = pend_ff;
      case (state_ff)
         ST_IDLE: begin
            if (do_load) begin
               msg_in        = msg_dec;
               pend_in       = learn_word;
               pend_valid_in = learn_en_ff && !msg_dec.release_evt;
               count_in      = CNT_W'(TABLE_ENTRIES);
               state_in      = action_en_ff ? ST_SCAN : ST_FLUSH;
            end
         end
         ST_SCAN: begin
            if (do_shift) begin
               if (hit[0]) begin
                  push          = pend_valid_ff;
                  push_word.last = 1'b0;
                  pend_in       = action_word;
                  pend_valid_in = 1'b1;
               end
               count_in = count_ff - CNT_W'(1);
               if (count_ff == CNT_W'(1)) begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               push           = 1'b1;
               push_word.last = 1'b1;
               pend_valid_in  = 1'b0;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // output register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (push) begin
         out_valid_in = 1'b1;
         out_in       = push_word;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         count_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
         count_ff      <= count_in;
      end
      msg_ff  <= msg_in;
      pend_ff <= pend_in;
      out_ff  <= out_in;
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.data  = out_ff;

endmodule

@@ verif/midi_message_action_matcher_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_message_action_matcher_core_tb: self-checking bench of the matcher
// Feeds table writes and raw MIDI words through the request channel, with
// random gaps on both channels. A table model in the bench predicts the learn
// and action words of every accepted message, and each response word is
// checked field by field against the oldest prediction. Both enables are
// swept over their settings through the APB port between phases.
// ----------------------------------------------------------------------------
module midi_message_action_matcher_core_tb;
   import mmam_pkg::*;

   localparam int TABLE_ENTRIES = 32;
   localparam int TARGET_BITS   = 8;
   localparam int DRAIN_CYCLES  = TABLE_ENTRIES + 8;
   localparam int LONG_STALL    = 300;
   localparam int QUIET_LIMIT   = 3000;

   // table slot as the bench keeps it
   typedef struct packed {
      logic [TARGET_BITS-1:0] target;
      entry_type              entry;
   } map_slot_type;

   logic        clock;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   mmam_req_if req_chan();
   mmam_rsp_if rsp_chan();

   midi_message_action_matcher_core #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .TARGET_BITS   (TARGET_BITS)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // bench copy of the table and registers
   map_slot_type map_table [TABLE_ENTRIES];
   logic         learn_on;
   logic         actions_on;

   req_word_type pending_words [$];
   rsp_word_type expected_events [$];

   int   error_count   = 0;
   int   quiet_cycles  = 0;
   int   send_gap      = 0;
   int   ready_wait    = 0;
   int   stalls_asked  = 0;
   int   stalls_served = 0;
   logic req_taken     = 1'b0;
   logic idle_off      = 1'b0;

   // clock
   initial begin
      clock = 1'b0;
      forever begin
         #5 clock = ~clock;
      end
   end

   // gap length: mostly none or short, now and then long
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (idle_off || roll < 50) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // update the table or predict the words one request causes
   function automatic void apply_word(req_word_type w);
      logic [4:0]   msg_chan;
      logic         msg_kind;
      logic         is_release;
      logic         have_prev;
      rsp_word_type ev;
      rsp_word_type prev;
      map_slot_type s;
      have_prev = 1'b0;
      prev = '0;
      if (w.func == FUNC_WRITE_ENTRY) begin
         if (w.entry_index < TABLE_ENTRIES) begin
            s.target          = w.entry_target[TARGET_BITS-1:0];
            s.entry.kind      = w.entry_kind;
            s.entry.number    = w.entry_number;
            s.entry.channel   = w.entry_channel;
            s.entry.momentary = w.entry_momentary;
            s.entry.button    = w.entry_button;
            map_table[w.entry_index] = s;
         end
         return;
      end
      msg_chan = {1'b0, w.status_byte[3:0]} + 5'd1;
      case (w.status_byte[7:4])
         STATUS_NOTE_OFF: begin
            msg_kind = KIND_NOTE;
            is_release = 1'b1;
         end
         STATUS_NOTE_ON: begin
            msg_kind = KIND_NOTE;
            is_release = (w.data_second == 7'd0);
         end
         STATUS_CONTROLLER: begin
            msg_kind = KIND_CONTROLLER;
            is_release = 1'b0;
         end
         default: return;
      endcase
      ev = '0;
      ev.channel = msg_chan;
      ev.message_kind = msg_kind;
      ev.control_number = w.data_first;
      // learn word comes first
      if (learn_on && !is_release) begin
         ev.event_kind = EVENT_LEARN;
         ev.pressed = 1'b1;
         prev = ev;
         have_prev = 1'b1;
      end
      // one action word per hit, ascending slot order
      if (actions_on) begin
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            s = map_table[i];
            if (s.target == '0 || s.entry.kind != msg_kind || s.entry.number != w.data_first)
               continue;
            if (s.entry.channel != 5'd0 && s.entry.channel != msg_chan)
               continue;
            if (is_release && !s.entry.momentary)
               continue;
            if (!is_release && s.entry.button && w.data_second == 7'd0)
               continue;
            ev.event_kind = EVENT_ACTION;
            ev.target = 8'(s.target);
            ev.action_value = is_release ? 7'd0 : w.data_second;
            ev.pressed = !is_release;
            if (have_prev) expected_events.push_back(prev);
            prev = ev;
            have_prev = 1'b1;
         end
      end
      if (have_prev) begin
         prev.last = 1'b1;
         expected_events.push_back(prev);
      end
   endfunction

   task automatic check_field(string name, int exp_val, int got_val);
      if (exp_val != got_val) begin
         $error("%s: expected %0d, got %0d", name, exp_val, got_val);
         error_count++;
      end
   endtask

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         send_gap <= 0;
      end else if (req_chan.valid && !req_taken) begin
         // word still on offer
      end else if (send_gap > 0) begin
         req_chan.valid <= 1'b0;
         send_gap <= send_gap - 1;
      end else if (pending_words.size() > 0) begin
         req_chan.data <= pending_words.pop_front();
         req_chan.valid <= 1'b1;
         send_gap <= pick_gap();
      end else begin
         req_chan.valid <= 1'b0;
      end
   end

   // response ready, with a long hold-off on request
   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         ready_wait <= 0;
      end else if (stalls_served < stalls_asked) begin
         stalls_served <= stalls_served + 1;
         rsp_chan.ready <= 1'b0;
         ready_wait <= LONG_STALL;
      end else if (ready_wait > 0) begin
         rsp_chan.ready <= 1'b0;
         ready_wait <= ready_wait - 1;
      end else begin
         rsp_chan.ready <= 1'b1;
         ready_wait <= pick_gap();
      end
   end

   // monitor: check response words, then predict from accepted requests
   always @(posedge clock) begin
      rsp_word_type got;
      rsp_word_type exp_ev;
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = rsp_chan.data;
            if (expected_events.size() == 0) begin
               $error("unexpected response word %h", got);
               error_count++;
            end else begin
               exp_ev = expected_events.pop_front();
               check_field("event_kind", exp_ev.event_kind, got.event_kind);
               check_field("channel", exp_ev.channel, got.channel);
               check_field("message_kind", exp_ev.message_kind, got.message_kind);
               check_field("control_number", exp_ev.control_number, got.control_number);
               check_field("target", exp_ev.target, got.target);
               check_field("action_value", exp_ev.action_value, got.action_value);
               check_field("pressed", exp_ev.pressed, got.pressed);
               check_field("last", exp_ev.last, got.last);
            end
         end
         if (req_chan.valid && req_chan.ready) apply_word(req_chan.data);
      end
      req_taken <= !reset && req_chan.valid && req_chan.ready;
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || (csr_psel && csr_penable && csr_pready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("midi_message_action_matcher_core_tb: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // apb write of one enable, then read it back
   task automatic csr_write(logic reg_idx, logic value);
      logic [31:0] noise;
      noise = $urandom();
      @(negedge clock);
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b1;
      csr_paddr = {reg_idx, 2'b00};
      csr_pwdata = {noise[31:1], value};
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (reg_idx == REG_LEARN_ENABLE) learn_on = value;
      else actions_on = value;
      @(negedge clock);
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      check_field(reg_idx == REG_LEARN_ENABLE ? "learn_enable" : "action_enable",
                  value, csr_prdata[0]);
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
   endtask

   task automatic set_enables(logic learn, logic action);
      csr_write(REG_LEARN_ENABLE, learn);
      csr_write(REG_ACTION_ENABLE, action);
   endtask

   // wait until every predicted word is out and the chain has finished
   task automatic wait_idle();
      while (pending_words.size() != 0 || req_chan.valid || expected_events.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // word with every field random, so unused fields toggle too
   function automatic req_word_type noise_word();
      req_word_type w;
      w.func            = 1'($urandom());
      w.entry_index     = 5'($urandom());
      w.entry_target    = 8'($urandom());
      w.entry_kind      = 1'($urandom());
      w.entry_number    = 7'($urandom());
      w.entry_channel   = 5'($urandom());
      w.entry_momentary = 1'($urandom());
      w.entry_button    = 1'($urandom());
      w.status_byte     = 8'($urandom());
      w.data_first      = 7'($urandom());
      w.data_second     = 7'($urandom());
      return w;
   endfunction

   task automatic push_entry(int idx, int target, logic kind, int number, int chan,
                             logic momentary, logic button);
      req_word_type w;
      w = noise_word();
      w.func = FUNC_WRITE_ENTRY;
      w.entry_index = 5'(idx);
      w.entry_target = 8'(target);
      w.entry_kind = kind;
      w.entry_number = 7'(number);
      w.entry_channel = 5'(chan);
      w.entry_momentary = momentary;
      w.entry_button = button;
      pending_words.push_back(w);
   endtask

   task automatic push_midi(int status, int first, int second);
      req_word_type w;
      w = noise_word();
      w.func = FUNC_MIDI;
      w.status_byte = 8'(status);
      w.data_first = 7'(first);
      w.data_second = 7'(second);
      pending_words.push_back(w);
   endtask

   // note or controller number, crowded onto a few values to get hits
   function automatic int pick_number();
      if ($urandom_range(0, 99) < 75) begin
         case ($urandom_range(0, 3))
            0: return 0;
            1: return 1;
            2: return 2;
            default: return 127;
         endcase
      end
      return $urandom_range(0, 127);
   endfunction

   task automatic push_random_entry();
      int roll;
      int chan;
      int target;
      roll = $urandom_range(0, 99);
      if (roll < 25) chan = 0;
      else if (roll < 80) chan = ($urandom_range(0, 2) == 0) ? 16 : $urandom_range(1, 2);
      else if (roll < 90) chan = $urandom_range(1, 16);
      else chan = $urandom_range(17, 31);
      target = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 255);
      push_entry($urandom_range(0, TABLE_ENTRIES - 1), target, 1'($urandom()),
                 pick_number(), chan, 1'($urandom()), 1'($urandom()));
   endtask

   task automatic push_random_midi();
      int roll;
      int nib;
      int status;
      int value;
      roll = $urandom_range(0, 99);
      nib = ($urandom_range(0, 9) < 6) ? (($urandom_range(0, 2) == 0) ? 15 : $urandom_range(0, 1))
                                       : $urandom_range(0, 15);
      if (roll < 25) begin
         status = {STATUS_NOTE_OFF, 4'(nib)};
      end else if (roll < 60) begin
         status = {STATUS_NOTE_ON, 4'(nib)};
      end else if (roll < 85) begin
         status = {STATUS_CONTROLLER, 4'(nib)};
      end else begin
         status = $urandom_range(0, 255);
         while (status[7:4] == STATUS_NOTE_OFF || status[7:4] == STATUS_NOTE_ON
                || status[7:4] == STATUS_CONTROLLER)
            status = $urandom_range(0, 255);
      end
      roll = $urandom_range(0, 99);
      if (roll < 25) value = 0;
      else if (roll < 35) value = 127;
      else value = $urandom_range(0, 127);
      push_midi(status, pick_number(), value);
   endtask

   task automatic run_random_phase(logic learn, logic action, int count, logic no_gaps);
      set_enables(learn, action);
      idle_off = no_gaps;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 99) < 25) push_random_entry();
         else push_random_midi();
      end
      wait_idle();
      idle_off = 1'b0;
   endtask

   // stimulus
   initial begin
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      learn_on = 1'b0;
      actions_on = 1'b0;
      for (int i = 0; i < TABLE_ENTRIES; i++) map_table[i] = '0;
      reset = 1'b1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: table extremes, release decoding, button skip, ignored status
      set_enables(1'b1, 1'b1);
      push_entry(0, 0, KIND_NOTE, 60, 0, 1'b1, 1'b0);         // no target, never fires
      push_entry(1, 255, KIND_NOTE, 60, 0, 1'b1, 1'b0);
      push_entry(2, 1, KIND_NOTE, 60, 1, 1'b0, 1'b1);
      push_entry(3, 128, KIND_CONTROLLER, 127, 16, 1'b1, 1'b1);
      push_entry(4, 7, KIND_NOTE, 60, 17, 1'b1, 1'b0);        // channel out of range
      push_entry(31, 85, KIND_CONTROLLER, 0, 0, 1'b0, 1'b0);
      push_entry(30, 200, KIND_NOTE, 127, 16, 1'b1, 1'b0);
      push_midi(8'h90, 60, 100);
      push_midi(8'h90, 60, 0);                                 // note on, zero velocity
      push_midi(8'h80, 60, 127);                               // note off with velocity
      push_midi(8'h91, 60, 0);
      push_midi(8'hBF, 127, 0);                                // button entry skipped
      push_midi(8'hBF, 127, 127);
      push_midi(8'hB0, 0, 0);
      push_midi(8'h9F, 127, 127);
      push_midi(8'h8F, 127, 0);
      push_midi(8'h00, 0, 0);                                  // data byte as status
      push_midi(8'h7F, 127, 127);
      push_midi(8'hA0, 60, 100);                               // poly pressure
      push_midi(8'hC5, 60, 100);                               // program change
      push_midi(8'hE0, 0, 127);                                // pitch bend
      push_midi(8'hF0, 1, 1);
      push_midi(8'hFF, 127, 127);
      push_midi(8'h90, 0, 1);
      wait_idle();

      // random phases over the enable settings
      run_random_phase(1'b1, 1'b1, 60, 1'b0);
      run_random_phase(1'b0, 1'b1, 56, 1'b0);
      run_random_phase(1'b1, 1'b0, 48, 1'b0);
      run_random_phase(1'b0, 1'b0, 40, 1'b0);
      run_random_phase(1'b1, 1'b1, 56, 1'b1);

      // every slot hits one note, while the receiver holds off
      set_enables(1'b1, 1'b1);
      for (int i = 0; i < TABLE_ENTRIES; i++)
         push_entry(i, $urandom_range(1, 255), KIND_NOTE, 5, 0, 1'b1, 1'b0);
      wait_idle();
      stalls_asked = stalls_asked + 1;
      for (int n = 0; n < 16; n++) begin
         if (n % 4 == 3) push_midi({STATUS_NOTE_OFF, 4'($urandom())}, 5, $urandom_range(0, 127));
         else push_midi({STATUS_NOTE_ON, 4'($urandom())}, 5, $urandom_range(1, 127));
      end
      wait_idle();

      if (error_count == 0) begin
         $display("midi_message_action_matcher_core_tb: clean");
      end else begin
         $display("midi_message_action_matcher_core_tb: errors");
      end
      $finish;
   end

endmodule
